### hw/rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, muted while reset is high
`define CLWC_ASSERT_DIS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// concurrent assertion that also holds across reset
`define CLWC_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

### hw/rtl/clwc_pkg.sv
// shared types and constants of the circular list with cursor
package clwc_pkg;

   // command kinds carried on the request tuser
   typedef enum logic [2:0] {
      MODE_APPEND = 3'd0,
      MODE_NEXT   = 3'd1,
      MODE_PREV   = 3'd2,
      MODE_REMOVE = 3'd3,
      MODE_LIST   = 3'd4,
      MODE_CLEAR  = 3'd5
   } mode_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_BAD_POS = 2'd3
   } status_type;

   // per-cycle write strobes broadcast to every cell
   typedef struct packed {
      logic clear_all;
      logic alloc;
      logic link_next;
      logic link_prev;
      logic drop;
   } cell_ctrl_type;

   // beat field widths
   localparam int MODE_BITS     = 3;
   localparam int VALUE_BITS    = 32;
   localparam int POS_BITS      = 5;
   localparam int STATUS_BITS   = 2;
   localparam int COUNT_BITS    = 5;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 48;

   // result beat field offsets
   localparam int RSP_STATUS_LSB = 0;
   localparam int RSP_ENTRY_LSB  = 2;
   localparam int RSP_POS_LSB    = 34;
   localparam int RSP_COUNT_LSB  = 39;
   localparam int RSP_CUR_BIT    = 44;

endpackage

### hw/rtl/clwc_cell.sv
// one slot of the list: entry, links, in-use flag and a link of the free-slot chain
module clwc_cell #(
   parameter int INDEX      = 0,
   parameter int SLOT_BITS  = 4,
   parameter int ENTRY_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  clwc_pkg::cell_ctrl_type ctrl,
   input  logic [ENTRY_BITS-1:0]   alloc_entry,
   input  logic [SLOT_BITS-1:0]    alloc_next,
   input  logic [SLOT_BITS-1:0]    alloc_prev,
   input  logic [SLOT_BITS-1:0]    link_next_addr,
   input  logic [SLOT_BITS-1:0]    link_next_val,
   input  logic [SLOT_BITS-1:0]    link_prev_addr,
   input  logic [SLOT_BITS-1:0]    link_prev_val,
   input  logic [SLOT_BITS-1:0]    drop_addr,
   input  logic                    find_in,
   input  logic [SLOT_BITS-1:0]    idx_in,
   output logic                    find_out,
   output logic [SLOT_BITS-1:0]    idx_out,
   output logic [SLOT_BITS-1:0]    next_link,
   output logic [SLOT_BITS-1:0]    prev_link,
   output logic [ENTRY_BITS-1:0]   entry
);

   localparam logic [SLOT_BITS-1:0] MY_SLOT = SLOT_BITS'(INDEX);

   logic                  used_ff, used_in;
   logic [SLOT_BITS-1:0]  next_ff, next_in;
   logic [SLOT_BITS-1:0]  prev_ff, prev_in;
   logic [ENTRY_BITS-1:0] entry_ff, entry_in;
   logic                  alloc_here;

   // lowest free slot: first cell whose left neighbors found none
   assign alloc_here = ctrl.alloc & ~used_ff & ~find_in;
   assign find_out   = find_in | ~used_ff;
   assign idx_out    = find_in ? idx_in : MY_SLOT;

   // slot updates from the broadcast strobes
   always_comb begin
      used_in  = used_ff;
      next_in  = next_ff;
      prev_in  = prev_ff;
      entry_in = entry_ff;
      if (ctrl.link_next && link_next_addr == MY_SLOT) begin
         next_in = link_next_val;
      end
      if (ctrl.link_prev && link_prev_addr == MY_SLOT) begin
         prev_in = link_prev_val;
      end
      if (ctrl.drop && drop_addr == MY_SLOT) begin
         used_in = 1'b0;
      end
      if (alloc_here) begin
         used_in  = 1'b1;
         next_in  = alloc_next;
         prev_in  = alloc_prev;
         entry_in = alloc_entry;
      end
      if (ctrl.clear_all) begin
         used_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
      next_ff  <= next_in;
      prev_ff  <= prev_in;
      entry_ff <= entry_in;
   end

   assign next_link = next_ff;
   assign prev_link = prev_ff;
   assign entry     = entry_ff;

endmodule

### hw/rtl/circular_list_with_cursor.sv
// circular doubly linked list with head and cursor, one slot per cell
// Commands come in on the req_ channel, one beat per command: tuser holds the
// command kind, tdata the entry value and the 1-based position for remove.
// Results leave on the rsp_ channel; every command gives one result beat with
// tlast high, except list on a non-empty list, which gives one beat per entry
// from the head on, tlast on the final one.
// One command is worked on at a time; req_tready is high only while idle.
// Steps from the accepted beat to its result loaded in the output register:
//   append, next, previous, clear, errors and removing the only entry: execute, result
//   remove at position p: execute, p - 1 link hops from the head, unlink, result
//   list of n entries: execute, then one beat per entry from the head on
// The walk over the links reads one slot per cycle while the output is not stalled.
// req_tready rises in the same cycle in which the last result becomes valid.
// The output register frees the channel: a new command is taken while the
// last result still waits. When rsp_tready is low the result holds and the
// list walk pauses until the beat is taken.
// Reset (synchronous) empties the list, puts head and cursor on slot 0 and
// drops any pending result; slot contents are not cleared.
module circular_list_with_cursor #(
   parameter int CAPACITY   = 16,
   parameter int ENTRY_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // entry_value[31:0], position[36:32], zero pad
   input  logic [2:0]  req_tuser,   // mode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // status[1:0], entry[33:2], list_position[38:34],
                                    // count[43:39], has_current[44], zero pad
   output logic        rsp_tlast
);

   localparam int SW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > clwc_pkg::POS_BITS) ? CW : clwc_pkg::POS_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK,
      ST_LIST,
      ST_RESP
   } state_type;

   // control state
   state_type            state_ff, state_in;
   logic [SW-1:0]        head_ff, head_in;
   logic [SW-1:0]        cursor_ff, cursor_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [SW-1:0]        walk_ff, walk_in;
   logic [CW-1:0]        steps_ff, steps_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // latched command and status
   logic [2:0]                       mode_ff, mode_in;
   logic [ENTRY_BITS-1:0]            value_ff, value_in;
   logic [clwc_pkg::POS_BITS-1:0]    pos_ff, pos_in;
   clwc_pkg::status_type             status_ff, status_in;

   // result register
   logic [clwc_pkg::STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [clwc_pkg::VALUE_BITS-1:0]  rsp_entry_ff, rsp_entry_in;
   logic [clwc_pkg::POS_BITS-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [clwc_pkg::COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic                             rsp_cur_ff, rsp_cur_in;
   logic                             rsp_last_ff, rsp_last_in;

   // cell row signals
   clwc_pkg::cell_ctrl_type ctrl;
   logic [SW-1:0]           alloc_next, alloc_prev;
   logic [SW-1:0]           link_next_addr, link_next_val;
   logic [SW-1:0]           link_prev_addr, link_prev_val;
   logic [SW-1:0]           drop_addr;
   logic [CAPACITY:0]       chain_find;
   logic [SW-1:0]           chain_idx [CAPACITY+1];
   logic [SW-1:0]           cell_next [CAPACITY];
   logic [SW-1:0]           cell_prev [CAPACITY];
   logic [ENTRY_BITS-1:0]   cell_entry [CAPACITY];

   // single read port into the row
   logic [SW-1:0]         rd_addr;
   logic                  rd_ok;
   logic [SW-1:0]         rd_next, rd_prev;
   logic [ENTRY_BITS-1:0] rd_entry;

   logic          out_free;
   logic          list_end;
   logic [PW-1:0] pos_ext, cnt_ext;

   // row of slot cells, free-slot search rippling left to right
   assign chain_find[0] = 1'b0;
   assign chain_idx[0]  = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      clwc_cell #(
         .INDEX      (i),
         .SLOT_BITS  (SW),
         .ENTRY_BITS (ENTRY_BITS)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (ctrl),
         .alloc_entry    (value_ff),
         .alloc_next     (alloc_next),
         .alloc_prev     (alloc_prev),
         .link_next_addr (link_next_addr),
         .link_next_val  (link_next_val),
         .link_prev_addr (link_prev_addr),
         .link_prev_val  (link_prev_val),
         .drop_addr      (drop_addr),
         .find_in        (chain_find[i]),
         .idx_in         (chain_idx[i]),
         .find_out       (chain_find[i+1]),
         .idx_out        (chain_idx[i+1]),
         .next_link      (cell_next[i]),
         .prev_link      (cell_prev[i]),
         .entry          (cell_entry[i])
      );
   end

   // read mux
   assign rd_ok    = (CW'(rd_addr) < CW'(CAPACITY));
   assign rd_next  = rd_ok ? cell_next[rd_addr]  : '0;
   assign rd_prev  = rd_ok ? cell_prev[rd_addr]  : '0;
   assign rd_entry = rd_ok ? cell_entry[rd_addr] : '0;

   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign list_end = (idx_ff == count_ff);
   assign pos_ext  = PW'(pos_ff);
   assign cnt_ext  = PW'(count_ff);

   // sequencer and result register next values
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      cursor_in     = cursor_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      steps_in      = steps_ff;
      idx_in        = idx_ff;
      mode_in       = mode_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_cur_in    = rsp_cur_ff;
      rsp_last_in   = rsp_last_ff;

      ctrl           = '0;
      alloc_next     = '0;
      alloc_prev     = '0;
      link_next_addr = '0;
      link_next_val  = '0;
      link_prev_addr = '0;
      link_prev_val  = '0;
      drop_addr      = '0;
      rd_addr        = cursor_ff;

      case (state_ff)
         // take a command beat
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in   = req_tuser;
               value_in  = ENTRY_BITS'(req_tdata[31:0]);
               pos_in    = req_tdata[36:32];
               status_in = clwc_pkg::STATUS_OK;
               state_in  = ST_EXEC;
            end
         end

         // first step of every command
         ST_EXEC: begin
            state_in = ST_RESP;
            case (mode_ff)
               clwc_pkg::MODE_APPEND: begin
                  rd_addr = head_ff;
                  if (!chain_find[CAPACITY]) begin
                     status_in = clwc_pkg::STATUS_FULL;
                  end else begin
                     ctrl.alloc = 1'b1;
                     count_in   = count_ff + CW'(1);
                     if (count_ff == '0) begin
                        alloc_next = chain_idx[CAPACITY];
                        alloc_prev = chain_idx[CAPACITY];
                        head_in    = chain_idx[CAPACITY];
                        cursor_in  = chain_idx[CAPACITY];
                     end else begin
                        alloc_next     = head_ff;
                        alloc_prev     = rd_prev;
                        ctrl.link_next = 1'b1;
                        link_next_addr = rd_prev;
                        link_next_val  = chain_idx[CAPACITY];
                        ctrl.link_prev = 1'b1;
                        link_prev_addr = head_ff;
                        link_prev_val  = chain_idx[CAPACITY];
                     end
                  end
               end
               clwc_pkg::MODE_NEXT: begin
                  if (count_ff == '0) begin
                     status_in = clwc_pkg::STATUS_EMPTY;
                  end else begin
                     cursor_in = rd_next;
                  end
               end
               clwc_pkg::MODE_PREV: begin
                  if (count_ff == '0) begin
                     status_in = clwc_pkg::STATUS_EMPTY;
                  end else begin
                     cursor_in = rd_prev;
                  end
               end
               clwc_pkg::MODE_REMOVE: begin
                  if (count_ff == '0) begin
                     status_in = clwc_pkg::STATUS_EMPTY;
                  end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                     status_in = clwc_pkg::STATUS_BAD_POS;
                  end else if (count_ff == CW'(1)) begin
                     ctrl.clear_all = 1'b1;
                     head_in        = '0;
                     cursor_in      = '0;
                     count_in       = '0;
                  end else begin
                     walk_in  = head_ff;
                     steps_in = CW'(pos_ext - PW'(1));
                     state_in = ST_WALK;
                  end
               end
               clwc_pkg::MODE_LIST: begin
                  if (count_ff == '0) begin
                     status_in = clwc_pkg::STATUS_EMPTY;
                  end else begin
                     walk_in  = head_ff;
                     idx_in   = CW'(1);
                     state_in = ST_LIST;
                  end
               end
               clwc_pkg::MODE_CLEAR: begin
                  ctrl.clear_all = 1'b1;
                  head_in        = '0;
                  cursor_in      = '0;
                  count_in       = '0;
               end
               default: begin
               end
            endcase
         end

         // hop to the target slot, then unlink it
         ST_WALK: begin
            rd_addr = walk_ff;
            if (steps_ff != '0) begin
               walk_in  = rd_next;
               steps_in = steps_ff - CW'(1);
            end else begin
               ctrl.link_next = 1'b1;
               link_next_addr = rd_prev;
               link_next_val  = rd_next;
               ctrl.link_prev = 1'b1;
               link_prev_addr = rd_next;
               link_prev_val  = rd_prev;
               ctrl.drop      = 1'b1;
               drop_addr      = walk_ff;
               if (walk_ff == head_ff) begin
                  head_in = rd_next;
               end
               if (walk_ff == cursor_ff) begin
                  cursor_in = rd_next;
               end
               count_in = count_ff - CW'(1);
               state_in = ST_RESP;
            end
         end

         // one entry beat per cycle from the head on, while the output register is free
         ST_LIST: begin
            rd_addr = walk_ff;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = clwc_pkg::STATUS_OK;
               rsp_entry_in  = clwc_pkg::VALUE_BITS'(rd_entry);
               rsp_pos_in    = clwc_pkg::POS_BITS'(idx_ff);
               rsp_count_in  = clwc_pkg::COUNT_BITS'(count_ff);
               rsp_cur_in    = (count_ff != '0);
               rsp_last_in   = list_end;
               walk_in       = rd_next;
               idx_in        = idx_ff + CW'(1);
               if (list_end) begin
                  state_in = ST_IDLE;
               end
            end
         end

         // single result beat: status and the entry under the cursor
         ST_RESP: begin
            rd_addr = cursor_ff;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_entry_in  = (count_ff != '0) ? clwc_pkg::VALUE_BITS'(rd_entry) : '0;
               rsp_pos_in    = '0;
               rsp_count_in  = clwc_pkg::COUNT_BITS'(count_ff);
               rsp_cur_in    = (count_ff != '0);
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         cursor_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         cursor_ff    <= cursor_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      walk_ff       <= walk_in;
      steps_ff      <= steps_in;
      idx_ff        <= idx_in;
      mode_ff       <= mode_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_cur_ff    <= rsp_cur_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // channel ports
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'b000, rsp_cur_ff, rsp_count_ff, rsp_pos_ff,
                        rsp_entry_ff, rsp_status_ff};

endmodule

### hw/rtl/clwc_checker.sv
// port-level checks of the circular list with cursor, bound to the top level
`include "assert_macros.svh"

module clwc_checker #(
   parameter int CAPACITY = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic [clwc_pkg::STATUS_BITS-1:0] f_status;
   logic [clwc_pkg::POS_BITS-1:0]    f_pos;
   logic [clwc_pkg::COUNT_BITS-1:0]  f_count;
   logic                             f_cur;
   logic                             stall;
   logic                             cur_ok;
   logic                             pos_ok;
   logic                             end_ok;

   // result beat fields
   assign f_status = rsp_tdata[clwc_pkg::RSP_STATUS_LSB +: clwc_pkg::STATUS_BITS];
   assign f_pos    = rsp_tdata[clwc_pkg::RSP_POS_LSB +: clwc_pkg::POS_BITS];
   assign f_count  = rsp_tdata[clwc_pkg::RSP_COUNT_LSB +: clwc_pkg::COUNT_BITS];
   assign f_cur    = rsp_tdata[clwc_pkg::RSP_CUR_BIT];
   assign stall    = rsp_tvalid & ~rsp_tready;

   // cursor flag agrees with the count while the count field is not wrapped
   assign cur_ok = (CAPACITY >= 32) || (f_cur == (f_count != '0));
   // listed beats always carry an ok status
   assign pos_ok = (f_pos == '0) || (f_status == clwc_pkg::STATUS_OK);
   // final listed beat sits at the position equal to the count
   assign end_ok = !rsp_tlast || (f_pos == '0) || (f_pos == f_count);

   `CLWC_ASSERT(a_reset_idle, clock, reset |=> !rsp_tvalid, "result beat right after reset")
   `CLWC_ASSERT_DIS(a_stall_hold, clock, reset, stall |=> rsp_tvalid && $stable(rsp_tdata), "stalled beat changed")
   `CLWC_ASSERT_DIS(a_cur_count, clock, reset, rsp_tvalid |-> cur_ok, "has_current disagrees with count")
   `CLWC_ASSERT_DIS(a_list_status, clock, reset, rsp_tvalid |-> pos_ok, "listed beat with error status")
   `CLWC_ASSERT_DIS(a_list_end, clock, reset, rsp_tvalid |-> end_ok, "list ended before the count")

endmodule

bind circular_list_with_cursor clwc_checker #(
   .CAPACITY (CAPACITY)
) u_clwc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

### verif/circular_list_with_cursor_checker.sv
// result checker for the circular list with cursor: predicts every beat and compares
`timescale 1ns / 1ps

module circular_list_with_cursor_checker
   import clwc_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic [MODE_BITS-1:0]     req_tuser,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     rsp_tlast,
   output int                       error_count,
   output int                       results_due,
   output logic [COUNT_BITS-1:0]    entries_held
);

   // one predicted result beat
   typedef struct packed {
      status_type            status;
      logic [VALUE_BITS-1:0] entry;
      logic [POS_BITS-1:0]   list_pos;
      logic [COUNT_BITS-1:0] count;
      logic                  has_cur;
      logic                  last;
   } list_beat_type;

   // shadow copy of the linked list
   logic [3:0]            fwd_link [CAPACITY];
   logic [3:0]            back_link [CAPACITY];
   logic [VALUE_BITS-1:0] slot_value [CAPACITY];
   logic [CAPACITY-1:0]   slot_busy;
   logic [3:0]            head_ptr;
   logic [3:0]            cursor_ptr;
   logic [COUNT_BITS-1:0] list_len;

   list_beat_type awaited_beats[$];

   // empty list, pointers back on slot 0
   task automatic empty_list();
      slot_busy  = '0;
      head_ptr   = '0;
      cursor_ptr = '0;
      list_len   = '0;
   endtask

   task automatic queue_beat(input status_type st, input logic [VALUE_BITS-1:0] value,
                             input logic [POS_BITS-1:0] pos, input logic is_last);
      list_beat_type beat;
      beat.status   = st;
      beat.entry    = value;
      beat.list_pos = pos;
      beat.count    = list_len;
      beat.has_cur  = (list_len != 0);
      beat.last     = is_last;
      awaited_beats.push_back(beat);
   endtask

   // apply one command to the shadow list and queue the beats it gives
   task automatic run_list_command(input logic [MODE_BITS-1:0] mode,
                                   input logic [VALUE_BITS-1:0] value,
                                   input logic [POS_BITS-1:0] pos);
      status_type st;
      logic [3:0] slot;
      logic [3:0] tail;
      logic [3:0] prv;
      logic [3:0] nxt;
      bit         found;
      st    = STATUS_OK;
      found = 0;
      slot  = '0;
      case (mode)
         MODE_APPEND: begin
            // lowest free slot goes in at the tail
            for (int s = 0; s < CAPACITY; s++) begin
               if (!found && !slot_busy[s]) begin
                  slot  = s[3:0];
                  found = 1;
               end
            end
            if (!found) begin
               st = STATUS_FULL;
            end else begin
               slot_value[slot] = value;
               slot_busy[slot]  = 1'b1;
               if (list_len == 0) begin
                  fwd_link[slot]  = slot;
                  back_link[slot] = slot;
                  head_ptr        = slot;
                  cursor_ptr      = slot;
               end else begin
                  tail                = back_link[head_ptr];
                  fwd_link[tail]      = slot;
                  back_link[slot]     = tail;
                  fwd_link[slot]      = head_ptr;
                  back_link[head_ptr] = slot;
               end
               list_len++;
            end
         end
         MODE_NEXT: begin
            if (list_len == 0) st = STATUS_EMPTY;
            else cursor_ptr = fwd_link[cursor_ptr];
         end
         MODE_PREV: begin
            if (list_len == 0) st = STATUS_EMPTY;
            else cursor_ptr = back_link[cursor_ptr];
         end
         MODE_REMOVE: begin
            if (list_len == 0) begin
               st = STATUS_EMPTY;
            end else if (pos < 1 || pos > list_len) begin
               st = STATUS_BAD_POS;
            end else if (list_len == 1) begin
               empty_list();
            end else begin
               // hop from the head to the victim, then unlink it
               slot = head_ptr;
               for (int i = 1; i < pos; i++) slot = fwd_link[slot];
               prv            = back_link[slot];
               nxt            = fwd_link[slot];
               fwd_link[prv]  = nxt;
               back_link[nxt] = prv;
               if (slot == head_ptr) head_ptr = nxt;
               if (slot == cursor_ptr) cursor_ptr = nxt;
               slot_busy[slot] = 1'b0;
               list_len--;
            end
         end
         MODE_LIST: begin
            if (list_len == 0) begin
               st = STATUS_EMPTY;
            end else begin
               // one beat per entry from the head on
               slot = head_ptr;
               for (int i = 0; i < list_len; i++) begin
                  queue_beat(STATUS_OK, slot_value[slot], POS_BITS'(i + 1), (i + 1 == list_len));
                  slot = fwd_link[slot];
               end
               return;
            end
         end
         MODE_CLEAR: empty_list();
         default: ;
      endcase
      queue_beat(st, (list_len != 0) ? slot_value[cursor_ptr] : '0, '0, 1'b1);
   endtask

   task automatic check_field(input string name, input logic [VALUE_BITS-1:0] want,
                              input logic [VALUE_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      list_beat_type want;
      if (reset) begin
         empty_list();
         awaited_beats.delete();
      end else begin
         // a result beat always belongs to an older command, so check it first
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_beats.size() == 0) begin
               $error("result beat with no command waiting: tdata 0x%0h, tlast %0b",
                      rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want = awaited_beats.pop_front();
               check_field("status", want.status, rsp_tdata[RSP_STATUS_LSB +: STATUS_BITS]);
               check_field("entry", want.entry, rsp_tdata[RSP_ENTRY_LSB +: VALUE_BITS]);
               check_field("list_position", want.list_pos,
                           rsp_tdata[RSP_POS_LSB +: POS_BITS]);
               check_field("count", want.count, rsp_tdata[RSP_COUNT_LSB +: COUNT_BITS]);
               check_field("has_current", want.has_cur, rsp_tdata[RSP_CUR_BIT]);
               check_field("last", want.last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) begin
            run_list_command(req_tuser, req_tdata[VALUE_BITS-1:0],
                             req_tdata[VALUE_BITS +: POS_BITS]);
         end
      end
      results_due  = awaited_beats.size();
      entries_held = list_len;
   end

endmodule

### verif/circular_list_with_cursor_test.sv
// testbench top for the circular list with cursor: stimulus, flow control and verdict
`timescale 1ns / 1ps

module circular_list_with_cursor_test;
   import clwc_pkg::*;

   localparam int CAPACITY     = 16;
   localparam int CLOCK_PERIOD = 4;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_BEATS = 260;
   localparam int QUIET_BEATS  = 40;
   localparam int LONG_HOLD    = 250;
   localparam int CYCLE_LIMIT  = 400000;

   // command codes the block treats as no operation
   localparam logic [MODE_BITS-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_BITS-1:0] MODE_SPARE_HI = 3'd7;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic [MODE_BITS-1:0]     req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;

   int                       error_count;
   int                       results_due;
   logic [COUNT_BITS-1:0]    entries_held;

   bit                       gaps_on   = 1'b1;
   bit                       stalls_on = 1'b1;
   int                       hold_asked  = 0;
   int                       hold_served = 0;
   int                       beats_sent  = 0;
   int unsigned              cycle_count = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   circular_list_with_cursor #(
      .CAPACITY   (CAPACITY),
      .ENTRY_BITS (VALUE_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   circular_list_with_cursor_checker #(
      .CAPACITY (CAPACITY)
   ) i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .error_count  (error_count),
      .results_due  (results_due),
      .entries_held (entries_held)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: random stall bursts, plus the long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_asked) begin
            hold_served++;
            rsp_tready = 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 11) - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // offer one command beat, wait for it to be taken, return at the next falling edge
   task automatic send_command(input logic [MODE_BITS-1:0] mode,
                               input logic [VALUE_BITS-1:0] value,
                               input logic [POS_BITS-1:0] pos);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = {3'b000, pos, value};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      @(negedge clock);
   endtask

   // let the sender sit until every predicted beat has come back
   task automatic drain_results();
      req_tvalid = 1'b0;
      do @(negedge clock); while (results_due != 0);
   endtask

   initial begin
      int random_start;
      int pick;
      int reps;
      bit long_hold_done;
      bit drain_done;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      long_hold_done = 1'b0;
      drain_done     = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // directed: empty-list errors and spare codes
      send_command(MODE_LIST, '0, '0);
      send_command(MODE_NEXT, '0, '0);
      send_command(MODE_PREV, '0, '0);
      send_command(MODE_REMOVE, '0, 5'd1);
      send_command(MODE_SPARE_LO, 32'hFFFF_FFFF, 5'd31);
      send_command(MODE_SPARE_HI, '0, '0);
      // removing the only entry empties the list
      send_command(MODE_APPEND, '0, '0);
      send_command(MODE_REMOVE, '0, 5'd1);
      // four entries, cursor steps both ways and wraps backward past the head
      send_command(MODE_APPEND, 32'hFFFF_FFFF, 5'd31);
      send_command(MODE_APPEND, '0, '0);
      send_command(MODE_APPEND, 32'hAAAA_AAAA, '0);
      send_command(MODE_APPEND, 32'h5555_5555, '0);
      send_command(MODE_NEXT, '0, '0);
      send_command(MODE_PREV, '0, '0);
      send_command(MODE_PREV, '0, '0);
      // bad positions: zero, far beyond, one past the count
      send_command(MODE_REMOVE, '0, 5'd0);
      send_command(MODE_REMOVE, '0, 5'd31);
      send_command(MODE_REMOVE, '0, 5'd5);
      // tail under the cursor, then the head
      send_command(MODE_REMOVE, '0, 5'd4);
      send_command(MODE_REMOVE, '0, 5'd1);
      send_command(MODE_LIST, '0, '0);
      send_command(MODE_CLEAR, '0, '0);
      send_command(MODE_CLEAR, '0, '0);

      // random sequences, starting with a fill past full
      random_start = beats_sent;
      pick         = 19;
      while (beats_sent < random_start + RANDOM_BEATS) begin
         if (beats_sent >= random_start + RANDOM_BEATS - QUIET_BEATS) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end
         if (!long_hold_done && beats_sent >= random_start + 100) begin
            long_hold_done = 1'b1;
            hold_asked++;
         end
         if (!drain_done && beats_sent >= random_start + 180) begin
            drain_done = 1'b1;
            drain_results();
         end
         if (pick <= 5) begin
            // grow by a few entries
            reps = $urandom_range(1, 5);
            repeat (reps) send_command(MODE_APPEND, $urandom, POS_BITS'($urandom));
         end else if (pick <= 8) begin
            // cursor walk
            reps = $urandom_range(2, 6);
            repeat (reps) begin
               send_command($urandom_range(0, 1) ? MODE_NEXT : MODE_PREV, $urandom,
                            POS_BITS'($urandom));
            end
         end else if (pick <= 11) begin
            // removes at valid positions, or an empty-list error
            reps = $urandom_range(1, 3);
            repeat (reps) begin
               send_command(MODE_REMOVE, $urandom, (entries_held == 0) ? POS_BITS'(1) :
                            POS_BITS'($urandom_range(1, entries_held)));
            end
         end else if (pick <= 13) begin
            send_command(MODE_LIST, $urandom, POS_BITS'($urandom));
         end else if (pick <= 17) begin
            // noise over every code and position
            send_command(MODE_BITS'($urandom_range(0, 7)), $urandom,
                         POS_BITS'($urandom_range(0, 31)));
         end else if (pick == 18) begin
            send_command(MODE_CLEAR, $urandom, POS_BITS'($urandom));
         end else begin
            // fill to capacity, then bounce off the full list
            while (entries_held < CAPACITY) send_command(MODE_APPEND, $urandom, '0);
            reps = $urandom_range(1, 2);
            repeat (reps) send_command(MODE_APPEND, $urandom, POS_BITS'($urandom));
            send_command(MODE_LIST, '0, '0);
         end
         pick = $urandom_range(0, 19);
      end

      // wait out the last results, then a quiet stretch for strays
      drain_results();
      repeat (3 * CAPACITY) @(posedge clock);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
